>>> sv/prs_pkg.sv
// package: request and result types, operation codes and mixing constants
`timescale 1ns / 1ps

package prs_pkg;

  typedef enum logic [2:0] {
    OP_WRITE  = 3'd0,
    OP_RAW    = 3'd1,
    OP_INT    = 3'd2,
    OP_FRAC   = 3'd3,
    OP_CHANCE = 3'd4
  } op_e;

  localparam logic [63:0] MIX_ADD  = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_MUL1 = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_MUL2 = 64'h94D0_49BB_1331_11EB;
  localparam logic [24:0] FRAC_ONE = 25'h100_0000;

  typedef struct packed {
    logic [2:0]         operation;
    logic [7:0]         seq_index;
    logic [63:0]        position;
    logic [63:0]        seed_value;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
    logic [24:0]        probability;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [31:0]        raw_value;
    logic signed [31:0] bounded_value;
    logic [23:0]        fraction;
    logic               hit;
  } rsp_t;

  typedef struct packed {
    logic [2:0]  op;
    logic        hdl_ok;
    logic [31:0] range_low;
    logic [31:0] lo_min;
    logic [31:0] span;
    logic [24:0] prob;
  } meta_t;

  function automatic logic [63:0] premix(input logic [63:0] v);
    logic [63:0] s;
    s = v + MIX_ADD;
    return s ^ (s >> 30);
  endfunction

endpackage

>>> sv/prs_if.sv
// interfaces: request and result channels
`timescale 1ns / 1ps

interface prs_req_if;
  import prs_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface prs_rsp_if;
  import prs_pkg::*;
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> sv/prs_seed_table.sv
// seed table: seed memory with registered read and per-sequence seeded flags
`timescale 1ns / 1ps

module prs_seed_table #(
  parameter int SEQ_COUNT = 16,
  parameter int IDX_W     = (SEQ_COUNT > 1) ? $clog2(SEQ_COUNT) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  logic [63:0]      wdata_i,
  input  logic             re_i,
  input  logic [IDX_W-1:0] raddr_i,
  output logic [63:0]      rdata_o,
  output logic             seeded_o
);
  logic [63:0]          mem_q [SEQ_COUNT];
  logic [63:0]          rdata_q;
  logic [SEQ_COUNT-1:0] flag_q;
  logic                 seeded_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q   <= '0;
      seeded_q <= 1'b0;
    end else begin
      if (we_i) begin
        flag_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        seeded_q <= flag_q[raddr_i];
      end
    end
  end

  assign rdata_o  = rdata_q;
  assign seeded_o = seeded_q;
endmodule

>>> sv/prs_mix.sv
// mix core: two 64-bit constant multiplies as 32-bit partial products, four stages
`timescale 1ns / 1ps

module prs_mix (
  input  logic        clk_i,
  input  logic [3:0]  en_i,
  input  logic [63:0] a_i,
  output logic [63:0] y_o
);
  import prs_pkg::*;

  logic [63:0] p0a_q, p0b_q;
  logic [31:0] p1a_q, p2a_q, p1b_q, p2b_q;
  logic [63:0] b_q, y_q;
  logic [63:0] sa, sb;

  assign sa = p0a_q + {p1a_q + p2a_q, 32'h0};
  assign sb = p0b_q + {p1b_q + p2b_q, 32'h0};

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      p0a_q <= 64'(a_i[31:0]) * 64'(MIX_MUL1[31:0]);
      p1a_q <= a_i[31:0] * MIX_MUL1[63:32];
      p2a_q <= a_i[63:32] * MIX_MUL1[31:0];
    end
    if (en_i[1]) begin
      b_q <= sa ^ (sa >> 27);
    end
    if (en_i[2]) begin
      p0b_q <= 64'(b_q[31:0]) * 64'(MIX_MUL2[31:0]);
      p1b_q <= b_q[31:0] * MIX_MUL2[63:32];
      p2b_q <= b_q[63:32] * MIX_MUL2[31:0];
    end
    if (en_i[3]) begin
      y_q <= sb ^ (sb >> 31);
    end
  end

  assign y_o = y_q;
endmodule

>>> sv/position_addressed_random_sequence.sv
// top level: seed table, two mix pipelines, scaling and result register
//
//  channel  | dir | handshake      | payload
//  req_i    | in  | valid / ready  | operation, seq_index, position, seed_value,
//           |     |                | range_low, range_high, probability
//  rsp_o    | out | valid / ready  | ok, raw_value, bounded_value, fraction, hit
//
// one request per cycle sustained while the result side takes results
// latency is set by the two hash rounds, each with two 64-bit multiplies done
// as 32-bit partial products, plus the seed memory read and the range multiply
// seed writes land at accept, so a later query reads the new seed directly
// reset clears the seeded flags and the stage valids; no clearing pass
// an empty stage lets the stages behind it advance; req_i stalls only when all
// stages hold requests and the result is not taken
`timescale 1ns / 1ps

module position_addressed_random_sequence #(
  parameter int SEQ_COUNT = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  prs_req_if.sink   req_i,
  prs_rsp_if.source rsp_o
);
  import prs_pkg::*;

  localparam int IDX_W = (SEQ_COUNT > 1) ? $clog2(SEQ_COUNT) : 1;
  localparam int NSTG  = 12;

  logic [NSTG:1]   v_q;
  logic [NSTG:1]   vin;
  logic [NSTG+1:1] rdy;

  meta_t       meta_in;
  meta_t       meta_q [1:11];
  logic        hdl_ok;
  logic [31:0] lo_min, hi_max;
  logic        swap;

  logic [63:0] x1_q;
  logic [7:0]  idx1_q;
  logic [63:0] seed_rd;
  logic        seeded;
  logic [63:0] seed_q [2:5];
  logic [63:0] mix_a, mix_b;
  logic [63:0] x6_q;
  logic [31:0] raw_eff;
  logic [23:0] frac_eff;
  logic        hit_d;
  logic [63:0] prod_q;
  logic [31:0] raw11_q;
  logic        hit11_q;
  rsp_t        out_d, out_q;

  // handshake chain
  always_comb begin
    rdy[NSTG+1] = rsp_o.ready;
    for (int k = NSTG; k >= 1; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign vin         = {v_q[NSTG-1:1], req_i.valid};
  assign req_i.ready = rdy[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= (rdy[NSTG:1] & vin) | (~rdy[NSTG:1] & v_q);
    end
  end

  // request decode and bound ordering
  always_comb begin
    hdl_ok = {1'b0, req_i.payload.seq_index} < 9'(SEQ_COUNT);
    swap   = req_i.payload.range_high < req_i.payload.range_low;
    lo_min = swap ? req_i.payload.range_high : req_i.payload.range_low;
    hi_max = swap ? req_i.payload.range_low : req_i.payload.range_high;
    meta_in.op        = req_i.payload.operation;
    meta_in.hdl_ok    = hdl_ok;
    meta_in.range_low = req_i.payload.range_low;
    meta_in.lo_min    = lo_min;
    meta_in.span      = hi_max - lo_min + 32'd1;
    meta_in.prob      = req_i.payload.probability;
  end

  prs_seed_table #(
    .SEQ_COUNT (SEQ_COUNT),
    .IDX_W     (IDX_W)
  ) u_seed_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .we_i     (req_i.valid && rdy[1] && hdl_ok &&
               (req_i.payload.operation == OP_WRITE)),
    .waddr_i  (req_i.payload.seq_index[IDX_W-1:0]),
    .wdata_i  (req_i.payload.seed_value),
    .re_i     (rdy[1]),
    .raddr_i  (req_i.payload.seq_index[IDX_W-1:0]),
    .rdata_o  (seed_rd),
    .seeded_o (seeded)
  );

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      meta_q[1] <= meta_in;
      x1_q      <= premix(req_i.payload.position);
      idx1_q    <= req_i.payload.seq_index;
    end
    if (rdy[2]) begin
      seed_q[2] <= seeded ? seed_rd : {56'h0, idx1_q};
    end
  end

  for (genvar k = 2; k <= 11; k++) begin : g_meta
    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        meta_q[k] <= meta_q[k-1];
      end
    end
  end

  for (genvar k = 3; k <= 5; k++) begin : g_seed
    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        seed_q[k] <= seed_q[k-1];
      end
    end
  end

  prs_mix u_mix_pos (
    .clk_i (clk_i),
    .en_i  (rdy[5:2]),
    .a_i   (x1_q),
    .y_o   (mix_a)
  );

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      x6_q <= premix(mix_a ^ seed_q[5]);
    end
  end

  prs_mix u_mix_seed (
    .clk_i (clk_i),
    .en_i  (rdy[10:7]),
    .a_i   (x6_q),
    .y_o   (mix_b)
  );

  // raw value, chance compare and range multiply
  always_comb begin
    raw_eff  = meta_q[10].hdl_ok ? mix_b[63:32] : 32'h0;
    frac_eff = raw_eff[31:8];
    if (meta_q[10].prob == 25'h0) begin
      hit_d = 1'b0;
    end else if (meta_q[10].prob >= FRAC_ONE) begin
      hit_d = 1'b1;
    end else begin
      hit_d = 25'(frac_eff) < meta_q[10].prob;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[11]) begin
      prod_q  <= 64'(raw_eff) * 64'(meta_q[10].span);
      raw11_q <= raw_eff;
      hit11_q <= hit_d;
    end
  end

  // result assembly
  always_comb begin
    out_d = '0;
    unique case (meta_q[11].op)
      OP_WRITE: begin
        out_d.ok = meta_q[11].hdl_ok;
      end
      OP_RAW, OP_INT, OP_FRAC, OP_CHANCE: begin
        out_d.ok        = meta_q[11].hdl_ok;
        out_d.raw_value = raw11_q;
        out_d.fraction  = raw11_q[31:8];
        if (meta_q[11].op == OP_INT) begin
          if (!meta_q[11].hdl_ok) begin
            out_d.bounded_value = meta_q[11].range_low;
          end else if (meta_q[11].span == 32'h0) begin
            out_d.bounded_value = raw11_q;
          end else begin
            out_d.bounded_value = meta_q[11].lo_min + prod_q[63:32];
          end
        end
        if (meta_q[11].op == OP_CHANCE) begin
          out_d.hit = hit11_q;
        end
      end
      default: begin
        out_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy[12]) begin
      out_q <= out_d;
    end
  end

  assign rsp_o.valid   = v_q[NSTG];
  assign rsp_o.payload = out_q;
endmodule

>>> sv/prs_checker.sv
// checker: port-level assertions for the top level, with its bind
`timescale 1ns / 1ps

module prs_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          req_ready_i,
  input logic          rsp_valid_i,
  input logic          rsp_ready_i,
  input prs_pkg::rsp_t rsp_payload_i
);
  import prs_pkg::*;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_payload_i))
    else $error("result changed while stalled");

  a_frac_raw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_payload_i.fraction == rsp_payload_i.raw_value[31:8])
    else $error("fraction does not match raw value");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_payload_i.ok |-> rsp_payload_i.raw_value == 32'h0)
    else $error("failed request carries a raw value");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_ready_i |-> rsp_valid_i && !rsp_ready_i)
    else $error("request stalled without a stalled result");
endmodule

bind position_addressed_random_sequence prs_checker u_prs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_payload_i (rsp_o.payload)
);

>>> sim/tb_position_addressed_random_sequence.sv
// testbench: directed and random requests against a built-in hash predictor, checked in order
`timescale 1ns / 1ps

module tb_position_addressed_random_sequence;
  import prs_pkg::*;

  localparam int SEQ_COUNT   = 16;
  localparam int RAND_ITEMS  = 900;
  localparam int HOLD_CYCLES = 150;
  localparam int DRAIN_WAIT  = 30;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t rsp;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  prs_req_if req_if ();
  prs_rsp_if rsp_if ();

  position_addressed_random_sequence #(
    .SEQ_COUNT(SEQ_COUNT)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  logic [63:0] seed_table [SEQ_COUNT];
  bit          seeded     [SEQ_COUNT];

  rsp_t      pending_draws [$];
  stim_row_t directed_rows [$];

  int mismatches   = 0;
  int results_seen = 0;
  bit hold_on      = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [63:0] finalize64(input logic [63:0] v);
    logic [63:0] x;
    x = v + MIX_ADD;
    x = (x ^ (x >> 30)) * MIX_MUL1;
    x = (x ^ (x >> 27)) * MIX_MUL2;
    return x ^ (x >> 31);
  endfunction

  function automatic rsp_t mk_rsp(input logic ok, input logic [31:0] raw,
                                  input logic signed [31:0] bounded,
                                  input logic [23:0] frac, input logic hit);
    rsp_t p;
    p.ok            = ok;
    p.raw_value     = raw;
    p.bounded_value = bounded;
    p.fraction      = frac;
    p.hit           = hit;
    return p;
  endfunction

  function automatic req_t mk_req(input logic [2:0] op, input logic [7:0] idx,
                                  input logic [63:0] pos, input logic [63:0] seed,
                                  input logic signed [31:0] lo,
                                  input logic signed [31:0] hi,
                                  input logic [24:0] prob);
    req_t r;
    r.operation   = op;
    r.seq_index   = idx;
    r.position    = pos;
    r.seed_value  = seed;
    r.range_low   = lo;
    r.range_high  = hi;
    r.probability = prob;
    return r;
  endfunction

  // predicts the result of a request; updates the seed table on a write to a valid handle
  function automatic rsp_t draw_result(input req_t r);
    rsp_t               p;
    bit                 hdl_ok;
    logic [63:0]        s;
    logic [63:0]        h;
    logic [31:0]        raw;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic signed [31:0] t;
    logic [31:0]        span;
    logic [63:0]        scaled;
    p      = '0;
    hdl_ok = r.seq_index < SEQ_COUNT;
    raw    = '0;
    case (r.operation)
      OP_WRITE: begin
        if (hdl_ok) begin
          seed_table[r.seq_index] = r.seed_value;
          seeded[r.seq_index]     = 1'b1;
          p.ok = 1'b1;
        end
      end
      OP_RAW, OP_INT, OP_FRAC, OP_CHANCE: begin
        if (hdl_ok) begin
          s   = seeded[r.seq_index] ? seed_table[r.seq_index] : 64'(r.seq_index);
          h   = finalize64(finalize64(r.position) ^ s);
          raw = h[63:32];
          p.ok = 1'b1;
        end
        p.raw_value = raw;
        p.fraction  = raw[31:8];
        if (r.operation == OP_INT) begin
          if (!hdl_ok) begin
            p.bounded_value = r.range_low;
          end else begin
            lo = r.range_low;
            hi = r.range_high;
            if (hi < lo) begin
              t  = lo;
              lo = hi;
              hi = t;
            end
            span = hi - lo + 32'd1;
            if (span == 32'd0) begin
              p.bounded_value = raw;
            end else begin
              scaled          = {32'd0, raw} * {32'd0, span};
              p.bounded_value = lo + scaled[63:32];
            end
          end
        end else if (r.operation == OP_CHANCE) begin
          if (r.probability == 25'd0) begin
            p.hit = 1'b0;
          end else if (r.probability >= FRAC_ONE) begin
            p.hit = 1'b1;
          end else begin
            p.hit = {1'b0, p.fraction} < r.probability;
          end
        end
      end
      default: begin
        p = '0;
      end
    endcase
    return p;
  endfunction

  function automatic req_t random_request();
    req_t        r;
    int          pick;
    logic [31:0] marks [4];
    marks[0] = 32'h8000_0000;
    marks[1] = 32'h7FFF_FFFF;
    marks[2] = 32'h0000_0000;
    marks[3] = 32'hFFFF_FFFF;
    pick = $urandom_range(0, 99);
    if (pick < 12) r.operation = OP_WRITE;
    else if (pick < 30) r.operation = OP_RAW;
    else if (pick < 55) r.operation = OP_INT;
    else if (pick < 72) r.operation = OP_FRAC;
    else if (pick < 95) r.operation = OP_CHANCE;
    else r.operation = 3'($urandom_range(5, 7));
    if ($urandom_range(0, 99) < 88) r.seq_index = 8'($urandom_range(0, SEQ_COUNT - 1));
    else r.seq_index = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 4) == 0) r.position = 64'($urandom_range(0, 63));
    else r.position = {$urandom, $urandom};
    r.seed_value = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: begin
        r.range_low  = marks[$urandom_range(0, 3)];
        r.range_high = marks[$urandom_range(0, 3)];
      end
      1: begin
        r.range_low  = $urandom;
        r.range_high = r.range_low + 32'($urandom_range(0, 100));
      end
      2: begin
        r.range_low  = 32'($urandom_range(0, 40)) - 32'd20;
        r.range_high = 32'($urandom_range(0, 40)) - 32'd20;
      end
      default: begin
        r.range_low  = $urandom;
        r.range_high = $urandom;
      end
    endcase
    case ($urandom_range(0, 7))
      0: r.probability = 25'd0;
      1: r.probability = FRAC_ONE;
      2: r.probability = 25'($urandom_range(32'h100_0000, 32'h1FF_FFFF));
      default: r.probability = 25'($urandom_range(1, 32'hFF_FFFF));
    endcase
    return r;
  endfunction

  function automatic int next_gap(input int n);
    int pick;
    if (hold_on || (n % 200) < 40) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_request(input req_t r, input int gap, input bit typed,
                              input rsp_t typed_rsp);
    rsp_t p;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= r;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    p = draw_result(r);
    pending_draws.push_back(typed ? typed_rsp : p);
  endtask

  task automatic add_row(input req_t r, input bit typed, input rsp_t p);
    stim_row_t row;
    row.req   = r;
    row.typed = typed;
    row.rsp   = p;
    directed_rows.push_back(row);
  endtask

  // result checker
  always @(posedge clk_i) begin
    rsp_t got;
    rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = rsp_if.payload;
      results_seen++;
      if (pending_draws.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: ok=%0b raw=%h bounded=%h frac=%h hit=%0b",
                   got.ok, got.raw_value, got.bounded_value, got.fraction, got.hit);
        end
      end else begin
        want = pending_draws.pop_front();
        if (got.ok !== want.ok || got.raw_value !== want.raw_value ||
            got.bounded_value !== want.bounded_value ||
            got.fraction !== want.fraction || got.hit !== want.hit) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d mismatch: expected ok=%0b raw=%h bounded=%h frac=%h hit=%0b",
                     results_seen, want.ok, want.raw_value, want.bounded_value,
                     want.fraction, want.hit);
            $display("  actual ok=%0b raw=%h bounded=%h frac=%h hit=%0b",
                     got.ok, got.raw_value, got.bounded_value, got.fraction, got.hit);
          end
        end
      end
    end
  end

  // result side ready, with one long hold-off
  initial begin
    bit held;
    int pick;
    held = 1'b0;
    rsp_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      if (!held && results_seen >= 250) begin
        hold_on = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_on = 1'b0;
        held    = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        rsp_if.ready <= 1'b1;
        repeat ($urandom_range(30, 80)) @(posedge clk_i);
      end else if (pick < 60) begin
        rsp_if.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end else if (pick < 95) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end else begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(15, 40)) @(posedge clk_i);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rsp_t none;
    none = '0;
    for (int i = 0; i < SEQ_COUNT; i++) begin
      seed_table[i] = '0;
      seeded[i]     = 1'b0;
    end
    rst_ni         <= 1'b0;
    req_if.valid   <= 1'b0;
    req_if.payload <= '0;

    // unseeded, then seeds at the extremes, bad handles ignored
    add_row(mk_req(OP_RAW, 8'd0, 64'd0, 64'd0, 32'sd0, 32'sd0, 25'd0), 1'b0, none);
    add_row(mk_req(OP_RAW, 8'd15, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 32'sd0, 32'sd0, 25'd0),
            1'b0, none);
    add_row(mk_req(OP_WRITE, 8'd0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'sd0, 32'sd0, 25'd0),
            1'b1, mk_rsp(1'b1, 32'd0, 32'sd0, 24'd0, 1'b0));
    add_row(mk_req(OP_WRITE, 8'd15, 64'd0, 64'd0, 32'sd0, 32'sd0, 25'd0),
            1'b1, mk_rsp(1'b1, 32'd0, 32'sd0, 24'd0, 1'b0));
    add_row(mk_req(OP_WRITE, 8'd16, 64'd0, 64'h1234_5678_9ABC_DEF0, 32'sd0, 32'sd0, 25'd0),
            1'b1, none);
    add_row(mk_req(OP_WRITE, 8'd255, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 32'sd0, 32'sd0, 25'd0),
            1'b1, none);
    add_row(mk_req(OP_RAW, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 32'sd0, 32'sd0, 25'd0),
            1'b0, none);
    add_row(mk_req(OP_RAW, 8'd15, 64'd0, 64'd0, 32'sd0, 32'sd0, 25'd0), 1'b0, none);
    add_row(mk_req(OP_RAW, 8'd16, 64'd5, 64'd0, 32'sd0, 32'sd0, 25'd0), 1'b1, none);
    // bounded integer: full range, reversed, single value, invalid handle
    add_row(mk_req(OP_INT, 8'd1, 64'd7, 64'd0, 32'h8000_0000, 32'h7FFF_FFFF, 25'd0),
            1'b0, none);
    add_row(mk_req(OP_INT, 8'd4, 64'd8, 64'd0, 32'h7FFF_FFFF, 32'h8000_0000, 25'd0),
            1'b0, none);
    add_row(mk_req(OP_INT, 8'd2, 64'd9, 64'd0, 32'sd5, -32'sd7, 25'd0), 1'b0, none);
    add_row(mk_req(OP_INT, 8'd3, 64'd10, 64'd0, 32'sd42, 32'sd42, 25'd0), 1'b0, none);
    add_row(mk_req(OP_INT, 8'd0, 64'd11, 64'd0, 32'sd0, 32'sd0, 25'd0), 1'b0, none);
    add_row(mk_req(OP_INT, 8'd200, 64'd12, 64'd0, -32'sd5, -32'sd100, 25'd0),
            1'b1, mk_rsp(1'b0, 32'd0, -32'sd5, 24'd0, 1'b0));
    // fraction and chance thresholds
    add_row(mk_req(OP_FRAC, 8'd5, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 32'sd0, 32'sd0, 25'd0),
            1'b0, none);
    add_row(mk_req(OP_FRAC, 8'd16, 64'd3, 64'd0, 32'sd0, 32'sd0, 25'd0), 1'b1, none);
    add_row(mk_req(OP_CHANCE, 8'd6, 64'd1, 64'd0, 32'sd0, 32'sd0, 25'd0), 1'b0, none);
    add_row(mk_req(OP_CHANCE, 8'd7, 64'd2, 64'd0, 32'sd0, 32'sd0, FRAC_ONE), 1'b0, none);
    add_row(mk_req(OP_CHANCE, 8'd8, 64'd3, 64'd0, 32'sd0, 32'sd0, 25'h1FF_FFFF), 1'b0, none);
    add_row(mk_req(OP_CHANCE, 8'd9, 64'd4, 64'd0, 32'sd0, 32'sd0, 25'd1), 1'b0, none);
    add_row(mk_req(OP_CHANCE, 8'd16, 64'd4, 64'd0, 32'sd0, 32'sd0, 25'd0), 1'b1, none);
    add_row(mk_req(OP_CHANCE, 8'd255, 64'd4, 64'd0, 32'sd0, 32'sd0, 25'd1),
            1'b1, mk_rsp(1'b0, 32'd0, 32'sd0, 24'd0, 1'b1));
    // unknown operations
    add_row(mk_req(3'd5, 8'd0, 64'd1, 64'd1, 32'sd1, 32'sd2, 25'd1), 1'b1, none);
    add_row(mk_req(3'd7, 8'd3, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                   32'h7FFF_FFFF, 32'h8000_0000, 25'h1FF_FFFF), 1'b1, none);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, next_gap(i + 100), directed_rows[i].typed,
                   directed_rows[i].rsp);
    end
    for (int n = 0; n < RAND_ITEMS; n++) begin
      send_request(random_request(), next_gap(n), 1'b0, none);
    end
    req_if.valid <= 1'b0;

    while (pending_draws.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (mismatches == 0 && pending_draws.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
